// ----- rtl/skle_pkg.sv -----
// Shared types and constants for the sorted key list engine.
package skle_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT,
        ST_DUMP
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] quantity;
        logic        [DATA_W-1:0] price_bits;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic    load_req;
        logic    inc_idx;
        logic    do_insert;
        logic    do_delete;
        logic    load_out;
        logic    out_entry;
        logic    out_last;
        status_t out_status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic at_end;
        logic key_lt;
        logic key_eq;
        logic last_entry;
    } dp_stat_t;

endpackage

// ----- rtl/skle_dp.sv -----
// Datapath: record table, walk index, entry count and output payload registers.
module skle_dp (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  skle_pkg::dp_cmd_t                      cmd,
    output skle_pkg::dp_stat_t                     stat,
    input  logic signed [skle_pkg::DATA_W-1:0]     s_item_key,
    input  logic signed [skle_pkg::DATA_W-1:0]     s_item_quantity,
    input  logic        [skle_pkg::DATA_W-1:0]     s_item_price_bits,
    output logic        [1:0]                      m_status,
    output logic signed [skle_pkg::DATA_W-1:0]     m_out_key,
    output logic signed [skle_pkg::DATA_W-1:0]     m_out_quantity,
    output logic        [skle_pkg::DATA_W-1:0]     m_out_price_bits,
    output logic        [skle_pkg::POS_W-1:0]      m_position,
    output logic                                   m_last
);

    skle_pkg::entry_t                     entry_reg [skle_pkg::DEPTH];
    skle_pkg::entry_t                     req_reg;
    skle_pkg::entry_t                     rd_entry;
    logic [skle_pkg::CNT_W-1:0]           idx_reg, idx_next;
    logic [skle_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [skle_pkg::CNT_W-1:0]           idx_inc;
    logic [31:0]                          pos_wide;

    logic        [1:0]                    status_reg;
    logic signed [skle_pkg::DATA_W-1:0]   key_reg, quantity_reg;
    logic        [skle_pkg::DATA_W-1:0]   price_reg;
    logic        [skle_pkg::POS_W-1:0]    position_reg;
    logic                                 last_reg;

    assign idx_inc  = idx_reg + skle_pkg::CNT_W'(1);
    assign rd_entry = entry_reg[idx_reg[skle_pkg::IDX_W-1:0]];
    assign pos_wide = 32'(idx_reg) + 32'd1;

    assign stat.full       = (count_reg == skle_pkg::CNT_W'(skle_pkg::DEPTH));
    assign stat.empty      = (count_reg == '0);
    assign stat.at_end     = (idx_reg == count_reg);
    assign stat.key_lt     = (rd_entry.key < req_reg.key);
    assign stat.key_eq     = (rd_entry.key == req_reg.key);
    assign stat.last_entry = (idx_inc == count_reg);

    always_comb begin
        idx_next   = idx_reg;
        count_next = count_reg;
        if (cmd.load_req) begin
            idx_next = '0;
        end else if (cmd.inc_idx) begin
            idx_next = idx_inc;
        end
        if (cmd.do_insert) begin
            count_next = count_reg + skle_pkg::CNT_W'(1);
        end else if (cmd.do_delete) begin
            count_next = count_reg - skle_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            count_reg <= '0;
        end else begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_reg.key        <= s_item_key;
            req_reg.quantity   <= s_item_quantity;
            req_reg.price_bits <= s_item_price_bits;
        end
    end

    // each cell takes its left or right neighbor, insert opens a gap at idx
    for (genvar j = 0; j < skle_pkg::DEPTH; j++) begin : g_cell
        always_ff @(posedge aclk) begin
            if (cmd.do_insert) begin
                if (skle_pkg::CNT_W'(j) == idx_reg) begin
                    entry_reg[j] <= req_reg;
                end else if (skle_pkg::CNT_W'(j) > idx_reg) begin
                    if (j > 0) begin
                        entry_reg[j] <= entry_reg[(j > 0) ? j - 1 : 0];
                    end
                end
            end else if (cmd.do_delete) begin
                if (skle_pkg::CNT_W'(j) >= idx_reg && j < skle_pkg::DEPTH - 1) begin
                    entry_reg[j] <= entry_reg[(j < skle_pkg::DEPTH - 1) ? j + 1 : j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            last_reg <= cmd.out_last;
            if (cmd.out_entry) begin
                status_reg   <= skle_pkg::STAT_OK;
                key_reg      <= rd_entry.key;
                quantity_reg <= rd_entry.quantity;
                price_reg    <= rd_entry.price_bits;
                position_reg <= pos_wide[skle_pkg::POS_W-1:0];
            end else begin
                status_reg   <= cmd.out_status;
                key_reg      <= req_reg.key;
                quantity_reg <= '0;
                price_reg    <= '0;
                position_reg <= '0;
            end
        end
    end

    assign m_status         = status_reg;
    assign m_out_key        = key_reg;
    assign m_out_quantity   = quantity_reg;
    assign m_out_price_bits = price_reg;
    assign m_position       = position_reg;
    assign m_last           = last_reg;

endmodule

// ----- rtl/skle_ctrl.sv -----
// Controller: sequences search, shift and dump, and owns the handshakes.
module skle_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_action,
    output logic               m_valid,
    input  logic               m_ready,
    input  skle_pkg::dp_stat_t stat,
    output skle_pkg::dp_cmd_t  cmd
);

    skle_pkg::state_t  state_reg, state_next;
    skle_pkg::action_t op_reg, op_next;
    skle_pkg::status_t status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= skle_pkg::ST_IDLE;
            op_reg      <= skle_pkg::ACT_NONE;
            status_reg  <= skle_pkg::STAT_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.out_status = status_reg;
        s_ready     = 1'b0;

        case (state_reg)
            skle_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_req = 1'b1;
                    op_next      = skle_pkg::action_t'(s_action);
                    case (skle_pkg::action_t'(s_action))
                        skle_pkg::ACT_INSERT: begin
                            if (stat.full) begin
                                status_next = skle_pkg::STAT_FULL;
                                state_next  = skle_pkg::ST_RESULT;
                            end else begin
                                state_next  = skle_pkg::ST_SEARCH;
                            end
                        end
                        skle_pkg::ACT_DELETE: begin
                            state_next = skle_pkg::ST_SEARCH;
                        end
                        skle_pkg::ACT_DUMP: begin
                            if (stat.empty) begin
                                status_next = skle_pkg::STAT_EMPTY;
                                state_next  = skle_pkg::ST_RESULT;
                            end else begin
                                state_next  = skle_pkg::ST_DUMP;
                            end
                        end
                        default: begin
                            state_next = skle_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            skle_pkg::ST_SEARCH: begin
                if (op_reg == skle_pkg::ACT_INSERT) begin
                    // stop at the first stored key that is not smaller
                    if (stat.at_end || !stat.key_lt) begin
                        cmd.do_insert = 1'b1;
                        status_next   = skle_pkg::STAT_OK;
                        state_next    = skle_pkg::ST_RESULT;
                    end else begin
                        cmd.inc_idx = 1'b1;
                    end
                end else begin
                    if (stat.at_end) begin
                        status_next = skle_pkg::STAT_NOT_FOUND;
                        state_next  = skle_pkg::ST_RESULT;
                    end else if (stat.key_eq) begin
                        cmd.do_delete = 1'b1;
                        status_next   = skle_pkg::STAT_OK;
                        state_next    = skle_pkg::ST_RESULT;
                    end else begin
                        cmd.inc_idx = 1'b1;
                    end
                end
            end
            skle_pkg::ST_RESULT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = skle_pkg::ST_IDLE;
                end
            end
            skle_pkg::ST_DUMP: begin
                if (out_free) begin
                    cmd.load_out  = 1'b1;
                    cmd.out_entry = 1'b1;
                    cmd.out_last  = stat.last_entry;
                    cmd.inc_idx   = 1'b1;
                    if (stat.last_entry) begin
                        state_next = skle_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = skle_pkg::ST_IDLE;
            end
        endcase

        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ----- rtl/sorted_key_list_engine_unit.sv -----
// Top level of the sorted key list engine: controller plus datapath.
// Keeps up to 16 records in ascending signed key order in a register table with one read
// port at the walk index. Insert and delete walk the table one entry per cycle, then shift
// all later entries in the same cycle that the walk ends; a dump sends one record per cycle
// while the result side does not stall. A full insert or an empty dump goes straight to
// its result. Items are taken one at a time; the next item is accepted once the last result
// of the current one sits in the output register, even if that result has not been taken.
module sorted_key_list_engine_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [1:0]                   s_action,
    input  logic signed [skle_pkg::DATA_W-1:0]  s_item_key,
    input  logic signed [skle_pkg::DATA_W-1:0]  s_item_quantity,
    input  logic        [skle_pkg::DATA_W-1:0]  s_item_price_bits,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [1:0]                   m_status,
    output logic signed [skle_pkg::DATA_W-1:0]  m_out_key,
    output logic signed [skle_pkg::DATA_W-1:0]  m_out_quantity,
    output logic        [skle_pkg::DATA_W-1:0]  m_out_price_bits,
    output logic        [skle_pkg::POS_W-1:0]   m_position,
    output logic                                m_last
);

    skle_pkg::dp_cmd_t  cmd;
    skle_pkg::dp_stat_t stat;

    skle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    skle_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_item_key        (s_item_key),
        .s_item_quantity   (s_item_quantity),
        .s_item_price_bits (s_item_price_bits),
        .m_status          (m_status),
        .m_out_key         (m_out_key),
        .m_out_quantity    (m_out_quantity),
        .m_out_price_bits  (m_out_price_bits),
        .m_position        (m_position),
        .m_last            (m_last)
    );

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid || m_ready))
        else $error("output register loaded while result still pending");

    // insert never grows a full table
    a_insert_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_insert |-> !stat.full)
        else $error("insert issued on full table");

    // delete only at a matching stored record
    a_delete_match: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.do_delete |-> (stat.key_eq && !stat.at_end))
        else $error("delete issued without a matching record");

    // a dump keeps the input side closed on the following cycle
    a_dump_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action == skle_pkg::ACT_DUMP) |=> !s_ready)
        else $error("input accepted right after a dump request");

endmodule
